// ----- rtl/nfa_bitset_recognizer_top_macros.svh -----
// assertion macros for the nfa bitset recognizer
// expects i_clk and i_rst_n in the scope of each use
`ifndef NFA_BITSET_RECOGNIZER_TOP_MACROS_SVH
`define NFA_BITSET_RECOGNIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define NFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nfa recognizer check failed");

`define NFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nfa recognizer check failed");

`else

`define NFA_ASSERT_NOW(label, ante, cons)

`define NFA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/nfa_br_pkg.sv -----
// types, command codes and defaults for the nfa bitset recognizer
// no dependencies
package nfa_br_pkg;

    localparam int NUM_STATES_DEF  = 32;
    localparam int NUM_LETTERS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int STATE_W  = 5;
    localparam int LETTER_W = 4;
    localparam int MASK_W   = 32;

    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END     = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATE_W-1:0]  from_state;
        logic [LETTER_W-1:0] letter;
        logic [STATE_W-1:0]  to_state;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [MASK_W-1:0] final_active;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_WR,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

// ----- rtl/nfa_bitset_recognizer_top.sv -----
// nfa bitset recognizer: transition table in one synchronous memory, active set in flops
// depends on nfa_br_pkg and nfa_bitset_recognizer_top_macros.svh
//
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_ready    i_in_data  (nfa_br_pkg::t_in_item)
// out       out  o_out_valid / i_out_ready  o_out_data (nfa_br_pkg::t_out_item)
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data (accept mask, 32 bits)
//
// add transition: read then write back of one table row
// consume symbol: one table row read per state, one memory port
// end of word: written into the output register; waits only while that register is full
// after reset all 2**(clog2(NUM_STATES)+clog2(NUM_LETTERS)) table rows (512 at the defaults)
// are swept to zero, with o_in_ready low; cfg writes are taken at any time
`include "nfa_bitset_recognizer_top_macros.svh"

module nfa_bitset_recognizer_top #(
    parameter int NUM_STATES  = nfa_br_pkg::NUM_STATES_DEF,
    parameter int NUM_LETTERS = nfa_br_pkg::NUM_LETTERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nfa_br_pkg::t_in_item          i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nfa_br_pkg::t_out_item         o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nfa_br_pkg::MASK_W-1:0] i_cfg_data
);

    localparam int SW        = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int LW        = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
    localparam int AW        = SW + LW;
    localparam int MEM_DEPTH = 1 << AW;

    localparam logic [SW-1:0]         LAST_STATE   = SW'(NUM_STATES - 1);
    localparam logic [NUM_STATES-1:0] START_ACTIVE = {{(NUM_STATES-1){1'b0}}, 1'b1};

    logic [NUM_STATES-1:0] r_rows [MEM_DEPTH];

    nfa_br_pkg::t_state        r_state, n_state;
    logic [AW-1:0]             r_clr_cnt, n_clr_cnt;
    logic [AW-1:0]             r_addr, n_addr;
    logic [NUM_STATES-1:0]     r_dst_mask, n_dst_mask;
    logic [LW-1:0]             r_letter, n_letter;
    logic [SW-1:0]             r_scan, n_scan;
    logic                      r_hit, n_hit;
    logic [NUM_STATES-1:0]     r_acc, n_acc;
    logic [NUM_STATES-1:0]     r_active, n_active;
    logic [NUM_STATES-1:0]     r_rdata;
    logic [nfa_br_pkg::MASK_W-1:0] r_accept_mask;
    logic                      r_out_valid, n_out_valid;
    nfa_br_pkg::t_out_item     r_out_data, n_out_data;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic [8:0]                w_from9, w_to9, w_letter9;
    logic                      w_add_ok, w_letter_ok;
    logic [AW-1:0]             w_in_addr;
    logic [NUM_STATES-1:0]     w_in_dst;
    logic [NUM_STATES-1:0]     w_acc_step;
    logic [63:0]               w_active_ext;
    logic                      w_mem_we, w_mem_re;
    logic [AW-1:0]             w_mem_addr;
    logic [NUM_STATES-1:0]     w_mem_wdata;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_from9     = 9'(i_in_data.from_state);
    assign w_to9       = 9'(i_in_data.to_state);
    assign w_letter9   = 9'(i_in_data.letter);
    assign w_letter_ok = w_letter9 < 9'(NUM_LETTERS);
    assign w_add_ok    = (w_from9 < 9'(NUM_STATES)) && (w_to9 < 9'(NUM_STATES)) && w_letter_ok;
    assign w_in_addr   = {w_from9[SW-1:0], w_letter9[LW-1:0]};
    assign w_in_dst    = START_ACTIVE << i_in_data.to_state;
    assign w_acc_step  = r_hit ? (r_acc | r_rdata) : r_acc;
    assign w_active_ext = 64'(r_active);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nfa_br_pkg::S_CLEAR: begin
                if (r_clr_cnt == '1) n_state = nfa_br_pkg::S_IDLE;
            end
            nfa_br_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.cmd == nfa_br_pkg::CMD_ADD && w_add_ok) begin
                        n_state = nfa_br_pkg::S_ADD_WR;
                    end else if (i_in_data.cmd == nfa_br_pkg::CMD_CONSUME && w_letter_ok) begin
                        n_state = nfa_br_pkg::S_SCAN;
                    end
                end
            end
            nfa_br_pkg::S_ADD_WR: n_state = nfa_br_pkg::S_IDLE;
            nfa_br_pkg::S_SCAN: begin
                if (r_scan == LAST_STATE) n_state = nfa_br_pkg::S_DRAIN;
            end
            nfa_br_pkg::S_DRAIN: n_state = nfa_br_pkg::S_IDLE;
            default: n_state = nfa_br_pkg::S_CLEAR;
        endcase
    end

    // memory controls and ready
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = w_in_addr;
        w_mem_wdata = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            nfa_br_pkg::S_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_clr_cnt;
            end
            nfa_br_pkg::S_IDLE: begin
                o_in_ready = (i_in_data.cmd != nfa_br_pkg::CMD_END) || w_out_free;
                w_mem_re   = w_in_acc && (i_in_data.cmd == nfa_br_pkg::CMD_ADD) && w_add_ok;
            end
            nfa_br_pkg::S_ADD_WR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_addr;
                w_mem_wdata = r_rdata | r_dst_mask;
            end
            nfa_br_pkg::S_SCAN: begin
                w_mem_re   = 1'b1;
                w_mem_addr = {r_scan, r_letter};
            end
            nfa_br_pkg::S_DRAIN: begin
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_addr      = r_addr;
        n_dst_mask  = r_dst_mask;
        n_letter    = r_letter;
        n_scan      = r_scan;
        n_hit       = r_hit;
        n_acc       = r_acc;
        n_active    = r_active;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            nfa_br_pkg::S_CLEAR: n_clr_cnt = r_clr_cnt + 1'b1;
            nfa_br_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_data.cmd)
                        nfa_br_pkg::CMD_ADD: begin
                            n_addr     = w_in_addr;
                            n_dst_mask = w_in_dst;
                        end
                        nfa_br_pkg::CMD_CONSUME: begin
                            if (w_letter_ok) begin
                                n_letter = w_letter9[LW-1:0];
                                n_scan   = '0;
                                n_hit    = 1'b0;
                                n_acc    = '0;
                            end else begin
                                n_active = '0;
                            end
                        end
                        nfa_br_pkg::CMD_END: begin
                            n_out_valid             = 1'b1;
                            n_out_data.final_active = w_active_ext[nfa_br_pkg::MASK_W-1:0];
                            n_out_data.accepted     =
                                |(w_active_ext[nfa_br_pkg::MASK_W-1:0] & r_accept_mask);
                            n_active                = START_ACTIVE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            nfa_br_pkg::S_ADD_WR: begin
            end
            nfa_br_pkg::S_SCAN: begin
                n_acc  = w_acc_step;
                n_hit  = r_active[r_scan];
                n_scan = r_scan + 1'b1;
            end
            nfa_br_pkg::S_DRAIN: begin
                n_active = w_acc_step;
                n_hit    = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_rows[w_mem_addr] <= w_mem_wdata;
        if (w_mem_re) r_rdata <= r_rows[w_mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nfa_br_pkg::S_CLEAR;
            r_clr_cnt     <= '0;
            r_scan        <= '0;
            r_hit         <= 1'b0;
            r_active      <= START_ACTIVE;
            r_accept_mask <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_scan      <= n_scan;
            r_hit       <= n_hit;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) r_accept_mask <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_dst_mask <= n_dst_mask;
        r_letter   <= n_letter;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    `NFA_ASSERT_NOW(a_no_request_in_clear, r_state == nfa_br_pkg::S_CLEAR, !o_in_ready)
    `NFA_ASSERT_NOW(a_no_write_in_scan, r_state == nfa_br_pkg::S_SCAN, !w_mem_we)
    `NFA_ASSERT_NEXT(a_scan_ends, (r_state == nfa_br_pkg::S_SCAN) && (r_scan == LAST_STATE),
        r_state == nfa_br_pkg::S_DRAIN)
    `NFA_ASSERT_NEXT(a_end_restarts, w_in_acc && (i_in_data.cmd == nfa_br_pkg::CMD_END),
        o_out_valid && (r_active == START_ACTIVE))

endmodule
